@@ sv/dadw_pkg.sv @@
// Shared types, constants and calendar helpers for the date advance block.
// Used by dadw_alu, dadw_seq and date_add_days_weekday_core; no dependencies.
`timescale 1ns / 1ps

package dadw_pkg;

    // Default upper year limit
    localparam int unsigned MAX_YEAR_DEF = 9999;

    // Field widths
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int NDAYS_W = 20;
    localparam int WD_W    = 3;
    localparam int YMOD_W  = 9;

    // Day-offset accumulator: day of year plus the largest day count
    localparam int ACC_W = 21;

    // Calendar constants
    localparam logic [ACC_W-1:0]   DAYS_400Y   = 21'd146097;
    localparam logic [ACC_W-1:0]   YEARS_CYCLE = 21'd400;
    localparam logic [ACC_W-1:0]   DAYS_YEAR   = 21'd365;
    localparam logic [ACC_W-1:0]   DAYS_LEAP   = 21'd366;
    localparam logic [YMOD_W-1:0]  YMOD_LAST   = 9'd399;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_LAST    = 5'd31;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_CHECK,
        ST_DOY,
        ST_ADDN,
        ST_Y400,
        ST_Y1,
        ST_MON,
        ST_FIN
    } t_state;

    // Shared unit operations
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    // Sequencer to datapath
    typedef struct packed {
        t_state st;
        logic   in_ready;
        logic   load_out;
    } t_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic ge;
        logic invalid;
        logic k_lt_m;
        logic k_lt_12;
        logic y_over;
        logic out_free;
    } t_stat;

    // Gregorian leap rule on the year modulo 400
    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        return (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200)
            && (ymod != 9'd300);
    endfunction

    // Month length; meaningless month codes fall to the default arm
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m) inside
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // Remainder by 7 of a narrow value: fold octal digits, then one correction
    function automatic logic [WD_W-1:0] mod7(input logic [9:0] v);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[9]);
        s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
        if (s2 >= 4'd7) begin
            s2 = s2 - 4'd7;
        end
        return s2[2:0];
    endfunction

    // Weekday of 1 January, given (year - 1) modulo 400; 0 is Sunday
    function automatic logic [WD_W-1:0] jan1_wd(input logic [YMOD_W-1:0] q);
        logic [1:0] c;
        logic [9:0] v;
        if (q >= 9'd300) begin
            c = 2'd3;
        end else if (q >= 9'd200) begin
            c = 2'd2;
        end else if (q >= 9'd100) begin
            c = 2'd1;
        end else begin
            c = 2'd0;
        end
        v = 10'(q) + 10'(q[8:2]) - 10'(c) + 10'd1;
        return mod7(v);
    endfunction

endpackage

@@ sv/date_add_days_weekday_core.sv @@
// Top level of the Gregorian date advance block with weekday.
// Depends on dadw_pkg, dadw_alu and dadw_seq.
`timescale 1ns / 1ps
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready    | start_day, start_month, start_year,
//           |                            | days_to_add
//  output   | o_out_valid / i_out_ready  | end_day, end_month, end_year, weekday,
//           |                            | date_invalid, year_overflow
//
//  A transaction steps the shared adder through its loops in turn: year modulo
//  400, day of year, 400-year strides, single years and months.
//  Input is taken only when the sequencer is idle; a finished result sits in the
//  output register so the next transaction can be taken while it waits.
//  A stalled output holds the sequencer in its final state until the register frees.
//  Reset is synchronous, active low, and clears the sequencer, the invalid and overflow flags and output valid.

module date_add_days_weekday_core #(
    parameter int unsigned MAX_YEAR = dadw_pkg::MAX_YEAR_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [dadw_pkg::DAY_W-1:0]     i_start_day,
    input  logic [dadw_pkg::MONTH_W-1:0]   i_start_month,
    input  logic [dadw_pkg::YEAR_W-1:0]    i_start_year,
    input  logic [dadw_pkg::NDAYS_W-1:0]   i_days_to_add,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [dadw_pkg::DAY_W-1:0]     o_end_day,
    output logic [dadw_pkg::MONTH_W-1:0]   o_end_month,
    output logic [dadw_pkg::YEAR_W-1:0]    o_end_year,
    output logic [dadw_pkg::WD_W-1:0]      o_weekday,
    output logic                           o_date_invalid,
    output logic                           o_year_overflow
);
    import dadw_pkg::*;

    // Working year width: the year may run up to one 400-year stride past the limit
    localparam int YW_MIN = $clog2(MAX_YEAR + 401);
    localparam int YW     = (YW_MIN > YEAR_W) ? YW_MIN : YEAR_W;

    localparam logic [YW-1:0]     MaxY    = YW'(MAX_YEAR);
    localparam logic [YEAR_W-1:0] SatYear = YEAR_W'(MAX_YEAR);
    localparam logic [WD_W-1:0]   WdSat   =
        mod7(10'(jan1_wd(YMOD_W'(MAX_YEAR % 400))) + 10'd6);

    t_ctrl w_ctrl;
    t_stat w_stat;

    // Transaction registers
    logic [DAY_W-1:0]   r_start_day;
    logic [MONTH_W-1:0] r_start_month;
    logic [YEAR_W-1:0]  r_start_year;
    logic [NDAYS_W-1:0] r_days;

    // Working registers
    logic [ACC_W-1:0]   r_acc;
    logic [YMOD_W-1:0]  r_ymod;
    logic [YW-1:0]      r_year;
    logic [MONTH_W-1:0] r_k;
    logic [WD_W-1:0]    r_wd;
    logic               r_inval;
    logic               r_ovf;

    // Output register
    logic               r_out_valid;
    logic [DAY_W-1:0]   r_out_day;
    logic [MONTH_W-1:0] r_out_month;
    logic [YEAR_W-1:0]  r_out_year;
    logic [WD_W-1:0]    r_out_wd;
    logic               r_out_inval;
    logic               r_out_ovf;

    // Shared unit signals
    t_alu_op          w_op;
    logic [ACC_W-1:0] w_b;
    logic [ACC_W-1:0] w_res;
    logic             w_ge;

    // Calendar decode
    logic             w_leap;
    logic [DAY_W-1:0] w_dim;
    logic [DAY_W-1:0] w_dim_in;
    logic [ACC_W-1:0] w_ylen;
    logic [YMOD_W-1:0] w_pmod;
    logic             w_invalid;

    assign w_leap   = is_leap(r_ymod);
    assign w_dim    = month_days(r_k, w_leap);
    assign w_dim_in = month_days(r_start_month, w_leap);
    assign w_ylen   = w_leap ? DAYS_LEAP : DAYS_YEAR;
    assign w_pmod   = (r_ymod == '0) ? YMOD_LAST : r_ymod - 9'd1;

    // Start date check against its month length and the year range
    assign w_invalid = (r_start_month == '0) || (r_start_month > MONTH_LAST)
        || (r_start_year == '0) || (YW'(r_start_year) > MaxY)
        || (r_start_day == '0) || (r_start_day > w_dim_in);

    // Operand selection for the shared unit
    always_comb begin
        w_op = ALU_ADD;
        w_b  = '0;
        case (w_ctrl.st)
            ST_MOD:  begin w_op = ALU_SUB; w_b = YEARS_CYCLE;    end
            ST_DOY:  begin w_op = ALU_ADD; w_b = ACC_W'(w_dim);  end
            ST_ADDN: begin w_op = ALU_ADD; w_b = ACC_W'(r_days); end
            ST_Y400: begin w_op = ALU_SUB; w_b = DAYS_400Y;      end
            ST_Y1:   begin w_op = ALU_SUB; w_b = w_ylen;         end
            ST_MON:  begin w_op = ALU_SUB; w_b = ACC_W'(w_dim);  end
            default: begin w_op = ALU_ADD; w_b = '0;             end
        endcase
    end

    dadw_alu u_alu (
        .i_op  (w_op),
        .i_a   (r_acc),
        .i_b   (w_b),
        .o_res (w_res),
        .o_ge  (w_ge)
    );

    // Status back to the sequencer
    always_comb begin
        w_stat.ge       = w_ge;
        w_stat.invalid  = w_invalid;
        w_stat.k_lt_m   = (r_k < r_start_month);
        w_stat.k_lt_12  = (r_k < MONTH_LAST);
        w_stat.y_over   = (r_year > MaxY);
        w_stat.out_free = !r_out_valid || i_out_ready;
    end

    dadw_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    assign o_in_ready = w_ctrl.in_ready;

    // Flags: clear on a new transaction, set by the check and the year walks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inval <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            case (w_ctrl.st)
                ST_IDLE:  if (i_in_valid) begin r_inval <= 1'b0; r_ovf <= 1'b0; end
                ST_CHECK: if (w_invalid) r_inval <= 1'b1;
                ST_Y400,
                ST_Y1:    if (w_stat.y_over) r_ovf <= 1'b1;
                default:  ;
            endcase
        end
    end

    // Datapath: one step of the shared unit per cycle
    always_ff @(posedge i_clk) begin
        case (w_ctrl.st)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_start_day   <= i_start_day;
                    r_start_month <= i_start_month;
                    r_start_year  <= i_start_year;
                    r_days        <= i_days_to_add;
                    r_acc         <= ACC_W'(i_start_year);
                end
            end
            // Reduce the start year modulo 400
            ST_MOD: begin
                if (w_ge) begin
                    r_acc <= w_res;
                end else begin
                    r_ymod <= r_acc[YMOD_W-1:0];
                end
            end
            // Seed the day offset, month walk and weekday of 1 January
            ST_CHECK: begin
                if (!w_invalid) begin
                    r_acc  <= ACC_W'(r_start_day) - ACC_W'(1);
                    r_k    <= MONTH_FIRST;
                    r_year <= YW'(r_start_year);
                    r_wd   <= jan1_wd(w_pmod);
                end
            end
            // Add the lengths of the months before the start month
            ST_DOY: begin
                if (w_stat.k_lt_m) begin
                    r_acc <= w_res;
                    r_k   <= r_k + 4'd1;
                end
            end
            ST_ADDN: begin
                r_acc <= w_res;
            end
            // Stride 400 years at a time; the weekday repeats every stride
            ST_Y400: begin
                if (!w_stat.y_over && w_ge) begin
                    r_acc  <= w_res;
                    r_year <= r_year + YW'(400);
                end
            end
            // Advance one year at a time
            ST_Y1: begin
                if (!w_stat.y_over) begin
                    if (w_ge) begin
                        r_acc  <= w_res;
                        r_year <= r_year + YW'(1);
                        r_ymod <= (r_ymod == YMOD_LAST) ? '0 : r_ymod + 9'd1;
                        r_wd   <= mod7(10'(r_wd) + (w_leap ? 10'd2 : 10'd1));
                    end else begin
                        r_k <= MONTH_FIRST;
                    end
                end
            end
            // Advance month by month, then add the day offset within the month to the weekday
            ST_MON: begin
                if (w_stat.k_lt_12 && w_ge) begin
                    r_acc <= w_res;
                    r_k   <= r_k + 4'd1;
                    r_wd  <= mod7(10'(r_wd) + 10'(mod7(10'(w_dim))));
                end else begin
                    r_wd <= mod7(10'(r_wd) + 10'(mod7(10'(r_acc[DAY_W-1:0]))));
                end
            end
            default: ;
        endcase
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_ctrl.load_out) begin
            r_out_inval <= r_inval;
            r_out_ovf   <= r_ovf;
            if (r_inval) begin
                r_out_day   <= r_start_day;
                r_out_month <= r_start_month;
                r_out_year  <= r_start_year;
                r_out_wd    <= '0;
            end else if (r_ovf) begin
                r_out_day   <= DAY_LAST;
                r_out_month <= MONTH_LAST;
                r_out_year  <= SatYear;
                r_out_wd    <= WdSat;
            end else begin
                r_out_day   <= r_acc[DAY_W-1:0] + 5'd1;
                r_out_month <= r_k;
                r_out_year  <= r_year[YEAR_W-1:0];
                r_out_wd    <= r_wd;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_end_day       = r_out_day;
    assign o_end_month     = r_out_month;
    assign o_end_year      = r_out_year;
    assign o_weekday       = r_out_wd;
    assign o_date_invalid  = r_out_inval;
    assign o_year_overflow = r_out_ovf;

    // Invalid start and year saturation exclude each other
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_inval && r_ovf))
        else $error("invalid and overflow flags both set");

    // An accepted transaction keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready after accepting a transaction");

    // A delivered weekday lies in Sunday..Saturday
    a_weekday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_weekday <= 3'd6))
        else $error("weekday out of range");

    // A computed date has a real month and day
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_date_invalid) |->
            (o_end_month >= 4'd1) && (o_end_month <= 4'd12) && (o_end_day >= 5'd1))
        else $error("computed date out of range");

endmodule

@@ sv/dadw_alu.sv @@
// Shared add/subtract unit with compare for the date advance block.
// Depends on dadw_pkg.
`timescale 1ns / 1ps

module dadw_alu (
    input  dadw_pkg::t_alu_op             i_op,
    input  logic [dadw_pkg::ACC_W-1:0]    i_a,
    input  logic [dadw_pkg::ACC_W-1:0]    i_b,
    output logic [dadw_pkg::ACC_W-1:0]    o_res,
    output logic                          o_ge
);
    import dadw_pkg::*;

    localparam int SUM_W = ACC_W + 1;

    logic [ACC_W-1:0] w_b;
    logic [SUM_W-1:0] w_sum;

    // Invert the operand and add one for subtraction
    assign w_b   = (i_op == ALU_SUB) ? ~i_b : i_b;
    assign w_sum = {1'b0, i_a} + {1'b0, w_b} + SUM_W'(i_op == ALU_SUB);

    // Carry out of the subtraction means a >= b
    assign o_res = w_sum[ACC_W-1:0];
    assign o_ge  = w_sum[ACC_W];

endmodule

@@ sv/dadw_seq.sv @@
// Sequencer for the date advance block: steps the shared unit through the year
// reduction, validation, day of year, day addition, year and month walks. Depends on dadw_pkg.
`timescale 1ns / 1ps

module dadw_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  dadw_pkg::t_stat i_stat,
    output dadw_pkg::t_ctrl o_ctrl
);
    import dadw_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_MOD;
            ST_MOD:   if (!i_stat.ge) n_state = ST_CHECK;
            ST_CHECK: n_state = i_stat.invalid ? ST_FIN : ST_DOY;
            ST_DOY:   if (!i_stat.k_lt_m) n_state = ST_ADDN;
            ST_ADDN:  n_state = ST_Y400;
            ST_Y400: begin
                if (i_stat.y_over) begin
                    n_state = ST_FIN;
                end else if (!i_stat.ge) begin
                    n_state = ST_Y1;
                end
            end
            ST_Y1: begin
                if (i_stat.y_over) begin
                    n_state = ST_FIN;
                end else if (!i_stat.ge) begin
                    n_state = ST_MON;
                end
            end
            ST_MON:   if (!(i_stat.k_lt_12 && i_stat.ge)) n_state = ST_FIN;
            ST_FIN:   if (i_stat.out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ctrl.st       = r_state;
        o_ctrl.in_ready = (r_state == ST_IDLE);
        o_ctrl.load_out = (r_state == ST_FIN) && i_stat.out_free;
    end

endmodule
